@@ src/lse_pkg.sv @@
// shared types and codes for the lifo stack engine
package lse_pkg;

  localparam int LSE_DEPTH = 64;
  localparam int WORD_W    = 32;

  // command codes
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_PRINT = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_POP   = 3'd3;
  localparam logic [2:0] OP_SWAP  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } lse_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_value;
    logic                     has_value;
    logic [1:0]               status;
    logic                     last;
  } lse_out_t;

  typedef enum logic [1:0] {
    RD_TOP  = 2'd0,
    RD_SEC  = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_PUSH    = 2'd0,
    WR_TOP_RD  = 2'd1,
    WR_SEC_TMP = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       tmp_load;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       ptr_load;
    logic       ptr_dec;
    logic       out_load;
    logic       out_has;
    logic [1:0] out_status;
    logic       out_last;
  } lse_ctl_t;

  typedef struct packed {
    logic [2:0] command;
    logic       empty;
    logic       short_stack;
    logic       full;
    logic       ptr_zero;
    logic       out_free;
  } lse_stat_t;

endpackage

@@ src/lse_dpath.sv @@
// stack memory, entry count, walk pointer and result register
module lse_dpath #(
  parameter int STACK_DEPTH = lse_pkg::LSE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  lse_pkg::lse_in_t  cmd_data,
  input  lse_pkg::lse_ctl_t ctl,
  output lse_pkg::lse_stat_t stat,
  output logic              res_valid,
  input  logic              res_stall,
  output lse_pkg::lse_out_t res_data
);
  import lse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] tmp;
  logic [2:0]        command;
  logic [WORD_W-1:0] value;
  logic [CW-1:0]     count;
  logic [AW-1:0]     ptr;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);

  always_comb begin
    unique case (ctl.rd_sel)
      RD_TOP:  rd_addr = cnt_m1[AW-1:0];
      RD_SEC:  rd_addr = cnt_m2[AW-1:0];
      RD_NEXT: rd_addr = ptr - AW'(1);
      default: rd_addr = cnt_m1[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (ctl.wr_sel)
      WR_PUSH: begin
        wr_addr = count[AW-1:0];
        wr_data = value;
      end
      WR_TOP_RD: begin
        wr_addr = cnt_m1[AW-1:0];
        wr_data = rd_data;
      end
      WR_SEC_TMP: begin
        wr_addr = cnt_m2[AW-1:0];
        wr_data = tmp;
      end
      default: begin
        wr_addr = count[AW-1:0];
        wr_data = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      command <= cmd_data.command;
      value   <= cmd_data.push_value;
    end
    if (ctl.tmp_load) begin
      tmp <= rd_data;
    end
    if (ctl.ptr_load) begin
      ptr <= cnt_m1[AW-1:0];
    end else if (ctl.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count <= cnt_m1;
    end
  end

  // result register, loaded only when free so a stalled result holds
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_data.data_value <= ctl.out_has ? rd_data : '0;
      res_data.has_value  <= ctl.out_has;
      res_data.status     <= ctl.out_status;
      res_data.last       <= ctl.out_last;
    end
  end

  always_comb begin
    stat.command     = command;
    stat.empty       = (count == '0);
    stat.short_stack = (count < CW'(2));
    stat.full        = (count >= CW'(STACK_DEPTH));
    stat.ptr_zero    = (ptr == '0);
    stat.out_free    = !res_valid || !res_stall;
  end

endmodule

@@ src/lse_ctrl.sv @@
// sequencer for the stack commands
module lse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  lse_pkg::lse_stat_t stat,
  output lse_pkg::lse_ctl_t  ctl
);
  import lse_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_PEEK   = 7'b0000100,
    S_SWAP_A = 7'b0001000,
    S_SWAP_B = 7'b0010000,
    S_SWAP_C = 7'b0100000,
    S_PRINT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.command)
          OP_PUSH: begin
            if (stat.out_free) begin
              ctl.out_load = 1'b1;
              ctl.out_last = 1'b1;
              if (stat.full) begin
                ctl.out_status = ST_FULL;
              end else begin
                ctl.out_status = ST_OK;
                ctl.wr_en      = 1'b1;
                ctl.wr_sel     = WR_PUSH;
                ctl.cnt_inc    = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          OP_PRINT, OP_PEEK: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                ctl.out_load   = 1'b1;
                ctl.out_last   = 1'b1;
                ctl.out_status = ST_EMPTY;
                state_next     = S_IDLE;
              end
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_TOP;
              if (stat.command == OP_PRINT) begin
                ctl.ptr_load = 1'b1;
                state_next   = S_PRINT;
              end else begin
                state_next = S_PEEK;
              end
            end
          end
          OP_POP: begin
            if (stat.out_free) begin
              ctl.out_load   = 1'b1;
              ctl.out_last   = 1'b1;
              ctl.out_status = stat.empty ? ST_EMPTY : ST_OK;
              ctl.cnt_dec    = !stat.empty;
              state_next     = S_IDLE;
            end
          end
          OP_SWAP: begin
            if (stat.short_stack) begin
              if (stat.out_free) begin
                ctl.out_load   = 1'b1;
                ctl.out_last   = 1'b1;
                ctl.out_status = ST_SHORT;
                state_next     = S_IDLE;
              end
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_TOP;
              state_next = S_SWAP_A;
            end
          end
          // unused codes give no result
          default: state_next = S_IDLE;
        endcase
      end
      S_PEEK: begin
        if (stat.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_has    = 1'b1;
          ctl.out_last   = 1'b1;
          ctl.out_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      S_SWAP_A: begin
        ctl.tmp_load = 1'b1;
        ctl.rd_en    = 1'b1;
        ctl.rd_sel   = RD_SEC;
        state_next   = S_SWAP_B;
      end
      S_SWAP_B: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_TOP_RD;
        state_next = S_SWAP_C;
      end
      S_SWAP_C: begin
        if (stat.out_free) begin
          ctl.wr_en      = 1'b1;
          ctl.wr_sel     = WR_SEC_TMP;
          ctl.out_load   = 1'b1;
          ctl.out_last   = 1'b1;
          ctl.out_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      S_PRINT: begin
        // read data holds while the result register is busy
        if (stat.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_has    = 1'b1;
          ctl.out_status = ST_OK;
          ctl.out_last   = stat.ptr_zero;
          if (stat.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            ctl.ptr_dec = 1'b1;
            ctl.rd_en   = 1'b1;
            ctl.rd_sel  = RD_NEXT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/lifo_stack_engine_core.sv @@
// lifo stack engine: one command per transaction, results from a single output register
// push, pop, errors: result loaded in decode; peek: decode reads the top, peek loads it
// swap: decode, swap_a, swap_b, swap_c, set by the single read and write port of the memory
// print all: one result per cycle from the print state while the output is not stalled
// the result shows in the cycle after the last step; a new command is taken after that step
// rst (synchronous) empties the stack and drops any pending result; memory contents are kept
module lifo_stack_engine_core #(
  parameter int STACK_DEPTH = lse_pkg::LSE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  lse_pkg::lse_in_t cmd_data,
  output logic             res_valid,
  input  logic             res_stall,
  output lse_pkg::lse_out_t res_data
);
  import lse_pkg::*;

  lse_ctl_t  ctl;
  lse_stat_t stat;

  lse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  lse_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_data),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
